FILE: design/ttd_pkg.sv
// ----------------------------------------------------------------------------
// ttd_pkg
// shared types, format codes and pixel helpers of the tiled texture decoder
// ----------------------------------------------------------------------------
package ttd_pkg;

  localparam int COORD_W = 13;
  localparam int MAX_DIM_DEFAULT = 1024;

  localparam logic [3:0] FMT_I4     = 4'd0;
  localparam logic [3:0] FMT_I8     = 4'd1;
  localparam logic [3:0] FMT_IA4    = 4'd2;
  localparam logic [3:0] FMT_IA8    = 4'd3;
  localparam logic [3:0] FMT_RGB565 = 4'd4;
  localparam logic [3:0] FMT_RGB5A3 = 4'd5;
  localparam logic [3:0] FMT_RGBA8  = 4'd6;
  localparam logic [3:0] FMT_CMPR   = 4'd14;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [3:0]         fmt;
    logic [2:0]         pos;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [15:0]        mask;
    logic [63:0]        word;
    logic [63:0]        ar;
  } entry_t;

  typedef struct packed {
    logic [2:0] dx;
    logic [2:0] dy;
  } offset_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic [2:0] cc;
  } pixel_t;

  function automatic logic fmt_known(input logic [3:0] fmt);
    case (fmt)
      FMT_I4, FMT_I8, FMT_IA4, FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_RGBA8,
      FMT_CMPR: fmt_known = 1'b1;
      default: fmt_known = 1'b0;
    endcase
  endfunction

  function automatic offset_t slot_offset(input logic [3:0] fmt, input logic [2:0] pos,
                                          input logic [3:0] s);
    offset_t o;
    case (fmt)
      FMT_I4: begin
        o.dx = s[2:0];
        o.dy = {pos[1:0], s[3]};
      end
      FMT_I8, FMT_IA4: begin
        o.dx = s[2:0];
        o.dy = {1'b0, pos[1:0]};
      end
      FMT_CMPR: begin
        o.dx = {pos[0], s[1:0]};
        o.dy = {pos[1], s[3:2]};
      end
      default: begin
        o.dx = {1'b0, s[1:0]};
        o.dy = {1'b0, pos[1:0]};
      end
    endcase
    return o;
  endfunction

  function automatic logic slot_used(input logic [3:0] fmt, input logic [2:0] pos,
                                     input logic [3:0] s);
    case (fmt)
      FMT_I4, FMT_CMPR: slot_used = 1'b1;
      FMT_I8, FMT_IA4: slot_used = ~s[3];
      FMT_IA8, FMT_RGB565, FMT_RGB5A3: slot_used = (s[3:2] == 2'd0);
      FMT_RGBA8: slot_used = (s[3:2] == 2'd0) && pos[2];
      default: slot_used = 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] x3(input logic [2:0] v);
    return {v, v, v[2:1]};
  endfunction

  function automatic logic [7:0] x4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] x5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] x6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

endpackage

FILE: design/tiled_texture_decoder_top.sv
// path: word queue, then the back end's current word, then the output register
// throughput: one pixel beat per cycle while the receiver is ready; a word holds the back
//   end until its pixels are out (up to 16 for I4 and CMPR, 8 for I8 and IA4, 4 otherwise)
// words with no visible pixel are dropped by the front and never reach the back end
// the four-entry word queue lets the front take words while pixels drain
// reset: synchronous; clears counters, queue and output; config returns to defaults
// ----------------------------------------------------------------------------
// tiled_texture_decoder_top
// decodes tiled texture words into pixels with x,y coordinates
// ----------------------------------------------------------------------------
module tiled_texture_decoder_top #(
  parameter int MAX_WIDTH  = ttd_pkg::MAX_DIM_DEFAULT,
  parameter int MAX_HEIGHT = ttd_pkg::MAX_DIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // source_word
  input  logic        s_tuser,   // start_of_image
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // pixel_x, pixel_y, red, green, blue, alpha, channel_count
  output logic        m_tlast    // last
);
  import ttd_pkg::*;

  logic   push, full, head_valid, pop;
  entry_t push_entry, head_entry;

  ttd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .q_push(push), .q_entry(push_entry), .q_full(full)
  );

  ttd_fifo u_fifo (
    .clk, .rst, .push, .push_entry, .full,
    .pop, .head_valid, .head_entry
  );

  ttd_back u_back (
    .clk, .rst, .q_valid(head_valid), .q_entry(head_entry), .q_pop(pop),
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

endmodule

FILE: design/ttd_front.sv
// ----------------------------------------------------------------------------
// ttd_front
// accepts source words, tracks tile position and builds the pixel slot mask
// ----------------------------------------------------------------------------
module ttd_front #(
  parameter int MAX_WIDTH  = ttd_pkg::MAX_DIM_DEFAULT,
  parameter int MAX_HEIGHT = ttd_pkg::MAX_DIM_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [10:0]     cfg_data,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [63:0]     s_tdata,   // source_word
  input  logic            s_tuser,   // start_of_image
  output logic            q_push,
  output ttd_pkg::entry_t q_entry,
  input  logic            q_full
);
  import ttd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH / 4 + 2);
  localparam int RW = $clog2(MAX_HEIGHT / 4 + 2);

  logic [3:0]  texture_format;
  logic [10:0] image_width;
  logic [10:0] image_height;

  logic [CW-1:0] tile_column, tile_column_next, col_e;
  logic [RW-1:0] tile_row, tile_row_next, row_e;
  logic [2:0]    word_in_tile, word_in_tile_next, wit_e;

  logic [63:0] ar_row [4];

  logic               accept, known, tw8, th8, wpt8, wit_end;
  logic [2:0]         pos;
  logic [COORD_W-1:0] w, h, tiles_x, tiles_y, bx, by;
  logic [15:0]        mask;
  offset_t            off;

  assign s_tready = ~q_full;
  assign accept   = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_format <= FMT_I4;
      image_width    <= 11'd1;
      image_height   <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT: texture_format <= cfg_data[3:0];
        REG_WIDTH:  image_width    <= cfg_data;
        REG_HEIGHT: image_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    known = fmt_known(texture_format);
    tw8   = (texture_format == FMT_I4) || (texture_format == FMT_I8) ||
            (texture_format == FMT_IA4) || (texture_format == FMT_CMPR);
    th8   = (texture_format == FMT_I4) || (texture_format == FMT_CMPR);
    wpt8  = (texture_format == FMT_RGBA8);

    if (image_width == 11'd0) w = COORD_W'(1);
    else if (COORD_W'(image_width) > COORD_W'(MAX_WIDTH)) w = COORD_W'(MAX_WIDTH);
    else w = COORD_W'(image_width);
    if (image_height == 11'd0) h = COORD_W'(1);
    else if (COORD_W'(image_height) > COORD_W'(MAX_HEIGHT)) h = COORD_W'(MAX_HEIGHT);
    else h = COORD_W'(image_height);

    tiles_x = tw8 ? ((w + COORD_W'(7)) >> 3) : ((w + COORD_W'(3)) >> 2);
    tiles_y = th8 ? ((h + COORD_W'(7)) >> 3) : ((h + COORD_W'(3)) >> 2);

    col_e = s_tuser ? '0 : tile_column;
    row_e = s_tuser ? '0 : tile_row;
    wit_e = s_tuser ? '0 : word_in_tile;

    pos = wpt8 ? wit_e : {1'b0, wit_e[1:0]};
    bx  = tw8 ? (COORD_W'(col_e) << 3) : (COORD_W'(col_e) << 2);
    by  = th8 ? (COORD_W'(row_e) << 3) : (COORD_W'(row_e) << 2);

    wit_end = wpt8 ? (wit_e == 3'd7) : (wit_e >= 3'd3);

    tile_column_next = col_e;
    tile_row_next    = row_e;
    word_in_tile_next = wit_e;
    if (known) begin
      if (wit_end) begin
        word_in_tile_next = '0;
        if (COORD_W'(col_e) + COORD_W'(1) >= tiles_x) begin
          tile_column_next = '0;
          if (COORD_W'(row_e) < tiles_y) tile_row_next = row_e + RW'(1);
        end else begin
          tile_column_next = col_e + CW'(1);
        end
      end else begin
        word_in_tile_next = wit_e + 3'd1;
      end
    end

    for (int s = 0; s < 16; s++) begin
      off = slot_offset(texture_format, pos, 4'(s));
      mask[s] = slot_used(texture_format, pos, 4'(s)) &&
                (bx + COORD_W'(off.dx) < w) && (by + COORD_W'(off.dy) < h);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_column  <= '0;
      tile_row     <= '0;
      word_in_tile <= '0;
    end else if (accept) begin
      tile_column  <= tile_column_next;
      tile_row     <= tile_row_next;
      word_in_tile <= word_in_tile_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wpt8 && !pos[2]) ar_row[pos[1:0]] <= s_tdata;
  end

  assign q_push = accept && known && (mask != 16'd0);

  always_comb begin
    q_entry.fmt  = texture_format;
    q_entry.pos  = pos;
    q_entry.bx   = bx;
    q_entry.by   = by;
    q_entry.mask = mask;
    q_entry.word = s_tdata;
    q_entry.ar   = ar_row[pos[1:0]];
  end

endmodule

FILE: design/ttd_fifo.sv
// ----------------------------------------------------------------------------
// ttd_fifo
// short queue of classified words between front and back
// ----------------------------------------------------------------------------
module ttd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ttd_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ttd_pkg::entry_t head_entry
);
  import ttd_pkg::*;

  entry_t     store [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign full       = (count == 3'd4);
  assign head_valid = (count != 3'd0);
  assign head_entry = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

FILE: design/ttd_back.sv
// ----------------------------------------------------------------------------
// ttd_back
// walks the slot mask of one word and decodes one pixel per beat
// ----------------------------------------------------------------------------
module ttd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  ttd_pkg::entry_t q_entry,
  output logic            q_pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [55:0]     m_tdata,   // pixel_x, pixel_y, red, green, blue, alpha, channel_count
  output logic            m_tlast    // last
);
  import ttd_pkg::*;

  entry_t      cur;
  logic        cur_valid;
  logic [15:0] cur_mask, low, rest;
  logic [3:0]  slot;
  logic        fire, done;
  offset_t     off;
  pixel_t      pix;
  logic [COORD_W-1:0] px_x, px_y;

  logic [7:0]  o_r, o_g, o_b, o_a;
  logic [2:0]  o_cc;
  logic [9:0]  o_x, o_y;
  logic        o_valid, o_last;

  function automatic logic [7:0] get_byte(input logic [63:0] wd, input logic [2:0] i);
    return wd[{~i, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [20:0] p;
    p = 21'(v) * 21'd683;
    return p[18:11];
  endfunction

  always_comb begin
    logic [7:0]  byt, hi, lo, rowb;
    logic [15:0] px, ar, c0, c1;
    logic [1:0]  idx;
    logic [7:0]  r0, g0, b0, r1, g1, b1;
    low  = cur_mask & (~cur_mask + 16'd1);
    slot = '0;
    for (int s = 0; s < 16; s++) begin
      if (low[s]) slot = 4'(s);
    end
    rest = cur_mask & ~low;
    done = (rest == 16'd0);
    fire = cur_valid && (!o_valid || m_tready);
    q_pop = q_valid && (!cur_valid || (fire && done));

    off  = slot_offset(cur.fmt, cur.pos, slot);
    px_x = cur.bx + COORD_W'(off.dx);
    px_y = cur.by + COORD_W'(off.dy);

    byt  = cur.fmt == FMT_I4 ? get_byte(cur.word, {1'b0, slot[3:2]} + {1'b0, slot[3:2]} +
                                        3'(slot[1]))
                             : get_byte(cur.word, slot[2:0]);
    px   = cur.word[{~slot[1:0], 4'b0000} +: 16];
    ar   = cur.ar[{~slot[1:0], 4'b0000} +: 16];
    hi   = px[15:8];
    lo   = px[7:0];
    c0   = cur.word[63:48];
    c1   = cur.word[47:32];
    rowb = get_byte(cur.word, {1'b1, slot[3:2]});
    idx  = rowb[{~slot[1:0], 1'b0} +: 2];
    r0 = x5(c0[15:11]); g0 = x6(c0[10:5]); b0 = x5(c0[4:0]);
    r1 = x5(c1[15:11]); g1 = x6(c1[10:5]); b1 = x5(c1[4:0]);

    pix = '0;
    case (cur.fmt)
      FMT_I4: begin
        pix.r  = slot[0] ? x4(byt[3:0]) : x4(byt[7:4]);
        pix.cc = 3'd1;
      end
      FMT_I8: begin
        pix.r  = byt;
        pix.cc = 3'd1;
      end
      FMT_IA4: begin
        pix.r  = x4(byt[7:4]);
        pix.g  = x4(byt[3:0]);
        pix.cc = 3'd2;
      end
      FMT_IA8: begin
        pix.r  = hi;
        pix.g  = lo;
        pix.cc = 3'd2;
      end
      FMT_RGB565: begin
        pix = '{x5(px[15:11]), x6(px[10:5]), x5(px[4:0]), 8'hFF, 3'd4};
      end
      FMT_RGB5A3: begin
        if (px[15]) pix = '{x5(px[14:10]), x5(px[9:5]), x5(px[4:0]), 8'hFF, 3'd4};
        else pix = '{x4(px[11:8]), x4(px[7:4]), x4(px[3:0]), x3(px[14:12]), 3'd4};
      end
      FMT_RGBA8: begin
        pix = '{ar[7:0], hi, lo, ar[15:8], 3'd4};
      end
      FMT_CMPR: begin
        pix.cc = 3'd4;
        pix.a  = 8'hFF;
        case (idx)
          2'd0: begin pix.r = r0; pix.g = g0; pix.b = b0; end
          2'd1: begin pix.r = r1; pix.g = g1; pix.b = b1; end
          2'd2: begin
            if (c0 > c1) begin
              pix.r = div3({1'b0, r0, 1'b0} + 10'(r1));
              pix.g = div3({1'b0, g0, 1'b0} + 10'(g1));
              pix.b = div3({1'b0, b0, 1'b0} + 10'(b1));
            end else begin
              pix.r = 8'((9'(r0) + 9'(r1)) >> 1);
              pix.g = 8'((9'(g0) + 9'(g1)) >> 1);
              pix.b = 8'((9'(b0) + 9'(b1)) >> 1);
            end
          end
          default: begin
            if (c0 > c1) begin
              pix.r = div3(10'(r0) + {1'b0, r1, 1'b0});
              pix.g = div3(10'(g0) + {1'b0, g1, 1'b0});
              pix.b = div3(10'(b0) + {1'b0, b1, 1'b0});
            end else begin
              pix.a = 8'd0;
            end
          end
        endcase
      end
      default: pix = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
    end else if (fire && done) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur      <= q_entry;
      cur_mask <= q_entry.mask;
    end else if (fire) begin
      cur_mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fire) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_x    <= px_x[9:0];
      o_y    <= px_y[9:0];
      o_r    <= pix.r;
      o_g    <= pix.g;
      o_b    <= pix.b;
      o_a    <= pix.a;
      o_cc   <= pix.cc;
      o_last <= done;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {1'b0, o_cc, o_a, o_b, o_g, o_r, o_y, o_x};
  assign m_tlast  = o_last;

`ifndef ASSERT_OFF
  a_mask_nonzero: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur_mask != 16'd0))
    else $error("active word with empty slot mask");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !(fire && done)) |-> !q_pop)
    else $error("queue popped while word still has pixels");

  a_fire_needs_room: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !m_tready) |=> (o_valid && $stable(o_x) && $stable(o_last)))
    else $error("output register overwritten while stalled");
`endif

endmodule

FILE: bench/tiled_texture_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// tiled_texture_decoder_top_tb
// runs a table of directed source words, then random phases of format and image
// size; checks each pixel beat against table values or a tile-walking decoder model
// ----------------------------------------------------------------------------
module tiled_texture_decoder_top_tb;
  import ttd_pkg::*;

  localparam int LIMIT = 200000;

  typedef struct {
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic [2:0] cc;
    logic       last;
  } pixel_beat_t;

  typedef struct {
    logic [3:0]  fmt;
    int          w;
    int          h;
    bit          sof;
    logic [63:0] word;
    bit          typed;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic [2:0]  cc;
  } texel_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_FORMAT;
  logic [10:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;

  tiled_texture_decoder_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder model state
  logic [3:0]  cur_fmt = FMT_I4;
  int          cur_w = 1, cur_h = 1;
  int          tile_col, tile_row, word_pos;
  logic [15:0] ar_half [16];
  pixel_beat_t word_pixels[$];
  pixel_beat_t pixel_q[$];

  int fails = 0;
  int cycles = 0;
  int ready_mode = 0;
  int hold_ticket = 0;
  int gap_max = 4;
  int burst_left = 0;
  texel_row_t rows[$];

  function automatic int rep3(logic [2:0] v); return {v, v, v[2:1]}; endfunction
  function automatic int rep4(logic [3:0] v); return {v, v}; endfunction
  function automatic int rep5(logic [4:0] v); return {v, v[4:2]}; endfunction
  function automatic int rep6(logic [5:0] v); return {v, v[5:4]}; endfunction

  function automatic void put_pixel(int x, int y, int r, int g, int b, int a, int cc);
    int cw, ch;
    cw = (cur_w == 0) ? 1 : (cur_w > 1024 ? 1024 : cur_w);
    ch = (cur_h == 0) ? 1 : (cur_h > 1024 ? 1024 : cur_h);
    if (x < cw && y < ch)
      word_pixels.push_back('{x[9:0], y[9:0], r[7:0], g[7:0], b[7:0], a[7:0], cc[2:0], 1'b0});
  endfunction

  // decodes one accepted word into word_pixels and walks the tile counters
  function automatic void decode_word(logic [63:0] wd, bit sof);
    int tw, th, wpt, pos, bx, by, cw, ch, x, y, idx, c0, c1;
    int r0, g0, b0, r1, g1, b1, pr, pg, pb, pa;
    logic [7:0]  bt [8];
    logic [15:0] px, ar;
    word_pixels.delete();
    if (sof) begin
      tile_col = 0;
      tile_row = 0;
      word_pos = 0;
    end
    case (cur_fmt)
      FMT_I4, FMT_CMPR: begin tw = 8; th = 8; wpt = 4; end
      FMT_I8, FMT_IA4: begin tw = 8; th = 4; wpt = 4; end
      FMT_IA8, FMT_RGB565, FMT_RGB5A3: begin tw = 4; th = 4; wpt = 4; end
      FMT_RGBA8: begin tw = 4; th = 4; wpt = 8; end
      default: return;
    endcase
    cw = (cur_w == 0) ? 1 : (cur_w > 1024 ? 1024 : cur_w);
    ch = (cur_h == 0) ? 1 : (cur_h > 1024 ? 1024 : cur_h);
    pos = word_pos % wpt;
    bx = tile_col * tw;
    by = tile_row * th;
    for (int i = 0; i < 8; i++) bt[i] = wd[63-8*i -: 8];
    if (cur_fmt == FMT_I4) begin
      for (int j = 0; j < 8; j++) begin
        y = by + 2 * pos + (j >> 2);
        x = bx + (j & 3) * 2;
        put_pixel(x, y, rep4(bt[j][7:4]), 0, 0, 0, 1);
        put_pixel(x + 1, y, rep4(bt[j][3:0]), 0, 0, 0, 1);
      end
    end else if (cur_fmt == FMT_I8 || cur_fmt == FMT_IA4) begin
      for (int j = 0; j < 8; j++)
        if (cur_fmt == FMT_I8) put_pixel(bx + j, by + pos, bt[j], 0, 0, 0, 1);
        else put_pixel(bx + j, by + pos, rep4(bt[j][7:4]), rep4(bt[j][3:0]), 0, 0, 2);
    end else if (cur_fmt == FMT_CMPR) begin
      c0 = {bt[0], bt[1]};
      c1 = {bt[2], bt[3]};
      r0 = rep5(c0[15:11]); g0 = rep6(c0[10:5]); b0 = rep5(c0[4:0]);
      r1 = rep5(c1[15:11]); g1 = rep6(c1[10:5]); b1 = rep5(c1[4:0]);
      for (int row = 0; row < 4; row++)
        for (int col = 0; col < 4; col++) begin
          idx = (bt[4+row] >> (6 - 2 * col)) & 3;
          pa = 255;
          if (idx == 0) begin pr = r0; pg = g0; pb = b0; end
          else if (idx == 1) begin pr = r1; pg = g1; pb = b1; end
          else if (c0 > c1) begin
            if (idx == 2) begin
              pr = (2*r0 + r1) / 3; pg = (2*g0 + g1) / 3; pb = (2*b0 + b1) / 3;
            end else begin
              pr = (r0 + 2*r1) / 3; pg = (g0 + 2*g1) / 3; pb = (b0 + 2*b1) / 3;
            end
          end else if (idx == 2) begin
            pr = (r0 + r1) / 2; pg = (g0 + g1) / 2; pb = (b0 + b1) / 2;
          end else begin
            pr = 0; pg = 0; pb = 0; pa = 0;
          end
          put_pixel(bx + (pos & 1) * 4 + col, by + (pos >> 1) * 4 + row, pr, pg, pb, pa, 4);
        end
    end else begin
      for (int j = 0; j < 4; j++) begin
        px = {bt[2*j], bt[2*j+1]};
        x = bx + j;
        y = by + (pos & 3);
        case (cur_fmt)
          FMT_IA8: put_pixel(x, y, px[15:8], px[7:0], 0, 0, 2);
          FMT_RGB565: put_pixel(x, y, rep5(px[15:11]), rep6(px[10:5]), rep5(px[4:0]), 255, 4);
          FMT_RGB5A3:
            if (px[15]) put_pixel(x, y, rep5(px[14:10]), rep5(px[9:5]), rep5(px[4:0]), 255, 4);
            else put_pixel(x, y, rep4(px[11:8]), rep4(px[7:4]), rep4(px[3:0]),
                           rep3(px[14:12]), 4);
          default:
            if (pos < 4) ar_half[(pos*4 + j) & 15] = px;
            else begin
              ar = ar_half[((pos & 3)*4 + j) & 15];
              put_pixel(x, y, ar[7:0], px[15:8], px[7:0], ar[15:8], 4);
            end
        endcase
      end
    end
    if (word_pos >= wpt - 1) begin
      word_pos = 0;
      if (tile_col + 1 >= (cw + tw - 1) / tw) begin
        tile_col = 0;
        if (tile_row < (ch + th - 1) / th) tile_row++;
      end else tile_col++;
    end else word_pos++;
    if (word_pixels.size() > 0) word_pixels[word_pixels.size()-1].last = 1'b1;
  endfunction

  // offers one word in bursts with random gaps, decodes it on acceptance
  task automatic send_word(logic [63:0] wd, bit sof);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tdata <= wd;
    s_tuser <= sof;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    decode_word(wd, sof);
  endtask

  task automatic drain_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_FORMAT: cur_fmt = val[3:0];
      REG_WIDTH: cur_w = val;
      default: cur_h = val;
    endcase
  endtask

  task automatic set_image(logic [3:0] fmt, int w, int h);
    drain_idle();
    write_reg(REG_FORMAT, {7'd0, fmt});
    write_reg(REG_WIDTH, w[10:0]);
    write_reg(REG_HEIGHT, h[10:0]);
    cfg_we <= 1'b0;
  endtask

  // receiver: stall pattern, long hold-off on request, checks every beat
  int hold_left = 0, hold_seen = 0;
  always @(posedge clk) begin
    pixel_beat_t e;
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_q.size() == 0) begin
        $error("pixel beat with nothing expected: %h", m_tdata);
        fails++;
      end else begin
        e = pixel_q.pop_front();
        if (m_tdata[9:0] != e.x) begin
          $error("pixel_x expected %0d got %0d", e.x, m_tdata[9:0]); fails++;
        end
        if (m_tdata[19:10] != e.y) begin
          $error("pixel_y expected %0d got %0d", e.y, m_tdata[19:10]); fails++;
        end
        if (m_tdata[27:20] != e.r) begin
          $error("red expected %h got %h", e.r, m_tdata[27:20]); fails++;
        end
        if (m_tdata[35:28] != e.g) begin
          $error("green expected %h got %h", e.g, m_tdata[35:28]); fails++;
        end
        if (m_tdata[43:36] != e.b) begin
          $error("blue expected %h got %h", e.b, m_tdata[43:36]); fails++;
        end
        if (m_tdata[51:44] != e.a) begin
          $error("alpha expected %h got %h", e.a, m_tdata[51:44]); fails++;
        end
        if (m_tdata[54:52] != e.cc) begin
          $error("channel_count expected %0d got %0d", e.cc, m_tdata[54:52]); fails++;
        end
        if (m_tlast != e.last) begin
          $error("last expected %0d got %0d", e.last, m_tlast); fails++;
        end
      end
    end
    if (hold_seen != hold_ticket) begin
      hold_seen = hold_ticket;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      default: m_tready <= (cycles % 7 > 2);
    endcase
  end

  initial begin
    logic [3:0] fmt;
    int n;
    logic [3:0] fmts [8] = '{FMT_I4, FMT_I8, FMT_IA4, FMT_IA8, FMT_RGB565, FMT_RGB5A3,
                             FMT_RGBA8, FMT_CMPR};

    // single-pixel images: value read straight off the format
    rows.push_back('{FMT_I8, 1, 1, 1, 64'hFF00_0000_0000_0000, 1, 8'hFF, 0, 0, 0, 1});
    rows.push_back('{FMT_I4, 1, 1, 1, 64'hF0FF_FFFF_FFFF_FFFF, 1, 8'hFF, 0, 0, 0, 1});
    rows.push_back('{FMT_IA4, 1, 1, 1, 64'h5A00_0000_0000_0000, 1, 8'h55, 8'hAA, 0, 0, 2});
    rows.push_back('{FMT_IA8, 1, 1, 1, 64'h1234_0000_0000_0000, 1, 8'h12, 8'h34, 0, 0, 2});
    rows.push_back('{FMT_RGB565, 1, 1, 1, 64'hFFFF_0000_0000_0000, 1,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, 4});
    rows.push_back('{FMT_RGB565, 1, 1, 1, 64'h0000_FFFF_FFFF_FFFF, 1, 0, 0, 0, 8'hFF, 4});
    rows.push_back('{FMT_RGB5A3, 1, 1, 1, 64'h8000_0000_0000_0000, 1, 0, 0, 0, 8'hFF, 4});
    rows.push_back('{FMT_RGB5A3, 1, 1, 1, 64'h7FFF_0000_0000_0000, 1,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, 4});
    rows.push_back('{FMT_CMPR, 1, 1, 1, 64'h0000_0000_FF00_0000, 1, 0, 0, 0, 0, 4});
    rows.push_back('{FMT_CMPR, 1, 1, 1, 64'hFFFF_0000_0000_0000, 1,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, 4});
    // unknown format, rgba8 halves, interpolation, clamped sizes, mid-tile format change
    rows.push_back('{4'd7, 8, 8, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0});
    for (int i = 0; i < 8; i++)
      rows.push_back('{FMT_RGBA8, 4, 4, i == 0, {$urandom, $urandom}, 0, 0, 0, 0, 0, 0});
    rows.push_back('{FMT_CMPR, 16, 16, 1, 64'hF800_07E0_1BE4_E41B, 0, 0, 0, 0, 0, 0});
    rows.push_back('{FMT_CMPR, 16, 16, 0, 64'h07E0_F800_1BE4_E41B, 0, 0, 0, 0, 0, 0});
    rows.push_back('{FMT_I8, 0, 2047, 1, {$urandom, $urandom}, 0, 0, 0, 0, 0, 0});
    rows.push_back('{FMT_I8, 0, 2047, 0, {$urandom, $urandom}, 0, 0, 0, 0, 0, 0});
    rows.push_back('{FMT_IA8, 1024, 1024, 0, {$urandom, $urandom}, 0, 0, 0, 0, 0, 0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) begin
      if (rows[k].fmt != cur_fmt || rows[k].w != cur_w || rows[k].h != cur_h)
        set_image(rows[k].fmt, rows[k].w, rows[k].h);
      send_word(rows[k].word, rows[k].sof);
      if (rows[k].typed)
        pixel_q.push_back('{0, 0, rows[k].r, rows[k].g, rows[k].b, rows[k].a, rows[k].cc, 1});
      else
        foreach (word_pixels[p]) pixel_q.push_back(word_pixels[p]);
    end

    for (int ph = 0; ph < 9; ph++) begin
      fmt = ($urandom_range(0, 9) == 0) ? 4'd15 : fmts[$urandom_range(0, 7)];
      // the long receiver hold needs every word to carry visible pixels
      if (ph == 2) fmt = FMT_I8;
      if (ph == 2) set_image(fmt, 40, 40);
      else case ($urandom_range(0, 5))
        0: set_image(fmt, 2047, $urandom_range(0, 1) ? 0 : 1024);
        1: set_image(fmt, $urandom_range(0, 3), $urandom_range(1, 40));
        default: set_image(fmt, $urandom_range(1, 40), $urandom_range(1, 40));
      endcase
      ready_mode = ph % 3;
      gap_max = (ph % 4 == 1) ? 0 : 5;
      n = $urandom_range(9, 14);
      for (int i = 0; i < n; i++) begin
        if (ph == 2 && i == 2) hold_ticket++;
        send_word({$urandom, $urandom},
                  (i == 0 && fmt == FMT_RGBA8) || $urandom_range(0, 19) == 0);
        foreach (word_pixels[p]) pixel_q.push_back(word_pixels[p]);
      end
    end

    drain_idle();
    if (pixel_q.size() != 0) fails++;
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
